### src/text_console_char_writer_top_assert.svh
// Assertion macros for the checker module of the text console writer.
// Needs nothing but a clock and an active-low reset in the including scope.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

### src/tccw_pkg.sv
// Shared types, codes and constants of the text console character writer.
// No dependencies; imported by the sequencer and the top level.
package tccw_pkg;

    localparam int SCREEN_ROWS_DEF    = 25;
    localparam int SCREEN_COLUMNS_DEF = 80;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;
    localparam logic [7:0] CHAR_BLANK    = 8'h20;

    localparam logic [7:0]  ATTR_RESET = 8'h0F;
    localparam logic [15:0] RESET_CELL = 16'h0F20;

    localparam logic ADDR_ATTR = 1'b0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_ADV,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_RD_WAIT,
        ST_DONE
    } tccw_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tccw_cmd_t;

    typedef struct packed {
        logic        load;
        logic [10:0] cursor_index;
        logic [15:0] cell_data;
    } tccw_result_t;

endpackage

### src/tccw_screen_ram.sv
// Screen cell memory: one write port, one read port with registered data.
// Depends on nothing; instantiated by the top level.
module tccw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/tccw_seq.sv
// Sequencer of the console writer: cursor state, shared address adder and
// the fill, scroll and read walks over the screen memory. Uses tccw_pkg.
module tccw_seq #(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80,
    parameter int AW             = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tccw_pkg::tccw_cmd_t   cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [7:0]            attr,
    input  logic                  out_free,
    output tccw_pkg::tccw_result_t res,
    output logic                  we,
    output logic [AW-1:0]         waddr,
    output logic [15:0]           wdata,
    output logic [AW-1:0]         raddr,
    input  logic [15:0]           rdata
);

    import tccw_pkg::*;

    localparam int CELLS     = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int CW        = $clog2(SCREEN_COLUMNS);
    localparam int RW        = $clog2(SCREEN_ROWS);
    localparam int COPY_LAST = (SCREEN_ROWS - 1) * SCREEN_COLUMNS - 1;
    localparam int IW        = ((AW > 11) ? AW : 11) + 1;

    localparam logic [AW-1:0] COLS_A      = AW'(SCREEN_COLUMNS);
    localparam logic [AW-1:0] ONE_A       = AW'(1);
    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_COPY   = AW'(COPY_LAST);
    localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_ROWS - 1);
    localparam logic [CW:0]   COLS_X      = (CW + 1)'(SCREEN_COLUMNS);
    localparam logic [CW:0]   TAB_STEP    = (CW + 1)'(8);
    localparam logic [CW:0]   TAB_MASK    = ~((CW + 1)'(7));
    localparam logic [IW-1:0] CELLS_I     = IW'(CELLS);

    tccw_state_t   state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    tccw_cmd_t     cmd_reg, cmd_next;
    logic [15:0]   data_reg, data_next;

    logic [AW-1:0] add_a, add_b, sum;
    logic [CW:0]   col_ext;
    logic          printable;
    logic          in_range;

    // Shared address adder.
    assign sum = add_a + add_b;

    assign printable = (cmd_reg.char_code >= CHAR_PRINT_LO)
                    && (cmd_reg.char_code <= CHAR_PRINT_HI);
    assign in_range  = IW'(cmd_reg.cell_index) < CELLS_I;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            base_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        data_reg <= data_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        add_a      = cnt_reg;
        add_b      = ONE_A;
        col_ext    = {1'b0, col_reg};
        cmd_ready  = 1'b0;
        res        = '0;
        we         = 1'b0;
        waddr      = cnt_reg;
        wdata      = RESET_CELL;
        raddr      = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Blank the memory to its reset pattern, one cell a cycle.
                we       = 1'b1;
                cnt_next = sum;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                data_next  = '0;
                state_next = ST_DONE;
                priority if (cmd_reg.op == OP_PUT)
                begin
                    add_a = base_reg;
                    add_b = AW'(col_reg);
                    if (printable)
                    begin
                        we      = 1'b1;
                        waddr   = sum;
                        wdata   = {attr, cmd_reg.char_code};
                        col_ext = {1'b0, col_reg} + (CW + 1)'(1);
                    end
                    else if (cmd_reg.char_code == CHAR_BS)
                    begin
                        if (col_reg != '0)
                        begin
                            col_ext = {1'b0, col_reg} - (CW + 1)'(1);
                        end
                    end
                    else if (cmd_reg.char_code == CHAR_TAB)
                    begin
                        col_ext = ({1'b0, col_reg} + TAB_STEP) & TAB_MASK;
                    end
                    else if (cmd_reg.char_code == CHAR_CR
                          || cmd_reg.char_code == CHAR_LF)
                    begin
                        col_ext = '0;
                    end
                    if (cmd_reg.char_code == CHAR_LF || col_ext >= COLS_X)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            cnt_next   = '0;
                            state_next = ST_SCR_RD;
                        end
                        else
                        begin
                            state_next = ST_ADV;
                        end
                    end
                    else
                    begin
                        col_next = col_ext[CW-1:0];
                    end
                end
                else if (cmd_reg.op == OP_READ)
                begin
                    raddr      = AW'(cmd_reg.cell_index);
                    state_next = ST_RD_WAIT;
                end
                else if (cmd_reg.op == OP_CLEAR)
                begin
                    cnt_next   = '0;
                    base_next  = '0;
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADV:
            begin
                add_a      = base_reg;
                add_b      = COLS_A;
                base_next  = sum;
                row_next   = row_reg + RW'(1);
                state_next = ST_DONE;
            end
            ST_SCR_RD:
            begin
                // Fetch the cell one row below the destination.
                add_b      = COLS_A;
                raddr      = sum;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                we       = 1'b1;
                wdata    = rdata;
                cnt_next = sum;
                if (cnt_reg == LAST_COPY)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_SCR_RD;
                end
            end
            ST_FILL:
            begin
                we       = 1'b1;
                wdata    = {attr, CHAR_BLANK};
                cnt_next = sum;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_RD_WAIT:
            begin
                data_next  = in_range ? rdata : 16'h0000;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free.
                add_a            = base_reg;
                add_b            = AW'(col_reg);
                res.load         = out_free;
                res.cursor_index = 11'(sum);
                res.cell_data    = data_reg;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/text_console_char_writer_top.sv
// Top level of the text console character writer: stream ports, APB
// attribute register, output register. Uses tccw_pkg, tccw_screen_ram, tccw_seq.
//
// Input stream (s_tvalid/s_tready/s_tdata/s_tuser): one word per command;
//   s_tuser is the op, s_tdata the character byte and the cell index for reads.
// Output stream (m_tvalid/m_tready/m_tdata): exactly one word per command,
//   the cursor's linear index and the read cell (zero for anything but a read).
// APB: register 0 at address 0 is the attribute byte for new characters and
//   blanks; write it only while no command is in flight.
// Timing: one command at a time, s_tready low meanwhile. A character or control
//   byte goes EXEC, then DONE, which loads its result once the output register is
//   free; moving down a row adds ADV, a read adds RD_WAIT. A clear fills every cell,
//   a scroll copies rows up and blanks the last: every walk goes through the one
//   memory port pair, a cell per cycle, a read and then a write per copied cell.
// Reset: the memory is swept to blank cells (0x0F20) with s_tready low; the APB
//   port works during the sweep.
// Stall: a result waits in the output register while m_tready is low; the next
//   command is still accepted and runs until its own result is due.
module text_console_char_writer_top #(
    parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: char_code [7:0], cell_index [18:8], zero pad [23:19]
    input  logic [23:0] s_tdata,
    // s_tuser: op [1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: cursor_index [10:0], cell_data [26:11], zero pad [31:27]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import tccw_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]   attr_reg;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;

    tccw_cmd_t    cmd;
    tccw_result_t res;
    logic         out_free;
    logic         we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]  wdata, rdata;

    // Attribute register; writes to any other address are dropped.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ATTR) ? {24'h000000, attr_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_ATTR))
        begin
            attr_reg <= pwdata[7:0];
        end
    end

    assign cmd.op         = s_tuser;
    assign cmd.char_code  = s_tdata[7:0];
    assign cmd.cell_index = s_tdata[18:8];

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_data_reg <= {5'b00000, res.cell_data, res.cursor_index};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    tccw_seq #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .AW             (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .attr      (attr_reg),
        .out_free  (out_free),
        .res       (res),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    tccw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

### src/tccw_checker.sv
// Port-level checks of the console writer, bound to the top level.
// Uses the assertion macros of text_console_char_writer_top_assert.svh.
`include "text_console_char_writer_top_assert.svh"

module tccw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result word holds.
    `TCCW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One command at a time: ready drops right after an accept.
    `TCCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A command never yields its result in the very next cycle.
    `TCCW_ASSERT_NEXT(a_min_latency, clk, rst_n, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

endmodule

bind text_console_char_writer_top tccw_checker u_tccw_checker (.*);
